>>> sv/lens_refraction_pixel_map_defines.svh
// Assertion macros shared by the lens pixel mapper RTL.
`ifndef LENS_REFRACTION_PIXEL_MAP_DEFINES_SVH
`define LENS_REFRACTION_PIXEL_MAP_DEFINES_SVH

// Implication checked on every clock edge outside reset.
`define LRPM_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Condition that must never hold outside reset.
`define LRPM_ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`endif

>>> sv/lrpm_pkg.sv
// Types and constants of the lens pixel mapper.
`default_nettype none
package lrpm_pkg;

    typedef struct packed {
        logic [11:0] pixel_col;
        logic [11:0] pixel_row;
    } pixel_t;

    typedef struct packed {
        logic [1:0]  action;
        logic [11:0] source_col;
        logic [11:0] source_row;
        logic [7:0]  fill_chan0;
        logic [7:0]  fill_chan1;
        logic [7:0]  fill_chan2;
        logic [7:0]  fill_chan3;
        logic [3:0]  fill_mask;
    } result_t;

    localparam logic [1:0] ACT_COPY = 2'd0;
    localparam logic [1:0] ACT_KEEP = 2'd1;
    localparam logic [1:0] ACT_FILL = 2'd2;

    localparam logic [1:0] SUR_KEEP  = 2'd0;
    localparam logic [1:0] SUR_BG    = 2'd1;
    localparam logic [1:0] SUR_TRANS = 2'd2;

    localparam logic [2:0] LAY_IDX   = 3'd0;
    localparam logic [2:0] LAY_IDXA  = 3'd1;
    localparam logic [2:0] LAY_RGB   = 3'd2;
    localparam logic [2:0] LAY_RGBA  = 3'd3;
    localparam logic [2:0] LAY_GRAY  = 3'd4;
    localparam logic [2:0] LAY_GRAYA = 3'd5;

    localparam logic [2:0] REG_WIDTH  = 3'd0;
    localparam logic [2:0] REG_HEIGHT = 3'd1;
    localparam logic [2:0] REG_INDEX  = 3'd2;
    localparam logic [2:0] REG_SURR   = 3'd3;
    localparam logic [2:0] REG_LAYOUT = 3'd4;
    localparam logic [2:0] REG_BGCOL  = 3'd5;

    localparam logic [15:0] INDEX_RESET = 16'd13926;
    localparam logic [15:0] INDEX_MIN   = 16'd8192;

    // per-axis refraction pipeline: radicand width and quotient width
    localparam int AX_SQRT_W = 48;
    localparam int AX_Q_W    = 46;
    localparam int AXIS_LAT  = 9 + AX_SQRT_W / 2 + AX_Q_W;

endpackage
`default_nettype wire

>>> sv/lrpm_div.sv
// Pipelined restoring divider, one quotient bit per stage.
`default_nettype none
module lrpm_div #(
    parameter int NUM_W = 66,
    parameter int DEN_W = 26,
    parameter int Q_W   = 40,
    parameter int PAY_W = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    input  logic [PAY_W-1:0] pay_in,
    output logic             out_valid,
    output logic [Q_W-1:0]   quo,
    output logic [PAY_W-1:0] pay_out
);
    // quotient must fit Q_W bits; then num >> Q_W is below den
    logic [NUM_W-1:0] num_hi;
    logic [DEN_W-1:0] rem_reg [Q_W];
    logic [Q_W-1:0]   low_reg [Q_W];
    logic [Q_W-1:0]   quo_reg [Q_W];
    logic [DEN_W-1:0] den_reg [Q_W];
    logic [PAY_W-1:0] pay_reg [Q_W];
    logic             v_reg   [Q_W];

    assign num_hi = num >> Q_W;

    for (genvar k = 0; k < Q_W; k++)
    begin : g_stage
        logic [DEN_W-1:0] rem_i;
        logic [Q_W-1:0]   low_i;
        logic [Q_W-1:0]   quo_i;
        logic [DEN_W-1:0] den_i;
        logic [PAY_W-1:0] pay_i;
        logic             v_i;
        logic [DEN_W:0]   trial;
        logic [DEN_W:0]   diff;
        logic             ge;

        if (k == 0)
        begin : g_first
            assign rem_i = num_hi[DEN_W-1:0];
            assign low_i = num[Q_W-1:0];
            assign quo_i = '0;
            assign den_i = den;
            assign pay_i = pay_in;
            assign v_i   = in_valid;
        end
        else
        begin : g_next
            assign rem_i = rem_reg[k-1];
            assign low_i = low_reg[k-1];
            assign quo_i = quo_reg[k-1];
            assign den_i = den_reg[k-1];
            assign pay_i = pay_reg[k-1];
            assign v_i   = v_reg[k-1];
        end

        assign trial = {rem_i, low_i[Q_W-1]};
        assign ge    = trial >= {1'b0, den_i};
        assign diff  = trial - {1'b0, den_i};

        always_ff @(posedge clk)
        begin
            rem_reg[k] <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            low_reg[k] <= {low_i[Q_W-2:0], 1'b0};
            quo_reg[k] <= {quo_i[Q_W-2:0], ge};
            den_reg[k] <= den_i;
            pay_reg[k] <= pay_i;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[k] <= 1'b0;
            else
                v_reg[k] <= v_i;
        end
    end

    assign out_valid = v_reg[Q_W-1];
    assign quo       = quo_reg[Q_W-1];
    assign pay_out   = pay_reg[Q_W-1];
endmodule
`default_nettype wire

>>> sv/lrpm_isqrt.sv
// Pipelined floor square root, one root bit per stage.
`default_nettype none
module lrpm_isqrt #(
    parameter int IN_W  = 40,
    parameter int PAY_W = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic [IN_W-1:0]   val,
    input  logic [PAY_W-1:0]  pay_in,
    output logic              out_valid,
    output logic [IN_W/2-1:0] root,
    output logic [PAY_W-1:0]  pay_out
);
    localparam int R = IN_W / 2;

    logic [IN_W-1:0]  val_reg  [R];
    logic [R-1:0]     root_reg [R];
    logic [R+1:0]     rem_reg  [R];
    logic [PAY_W-1:0] pay_reg  [R];
    logic             v_reg    [R];

    for (genvar k = 0; k < R; k++)
    begin : g_stage
        logic [IN_W-1:0]  val_i;
        logic [R-1:0]     root_i;
        logic [R+1:0]     rem_i;
        logic [PAY_W-1:0] pay_i;
        logic             v_i;
        logic [R+3:0]     trial;
        logic [R+3:0]     sub;
        logic [R+3:0]     diff;
        logic             ge;

        if (k == 0)
        begin : g_first
            assign val_i  = val;
            assign root_i = '0;
            assign rem_i  = '0;
            assign pay_i  = pay_in;
            assign v_i    = in_valid;
        end
        else
        begin : g_next
            assign val_i  = val_reg[k-1];
            assign root_i = root_reg[k-1];
            assign rem_i  = rem_reg[k-1];
            assign pay_i  = pay_reg[k-1];
            assign v_i    = v_reg[k-1];
        end

        assign trial = {rem_i, val_i[IN_W-1 -: 2]};
        assign sub   = {2'b00, root_i, 2'b01};
        assign ge    = trial >= sub;
        assign diff  = trial - sub;

        always_ff @(posedge clk)
        begin
            // remainder never exceeds twice the partial root
            rem_reg[k]  <= ge ? diff[R+1:0] : trial[R+1:0];
            root_reg[k] <= {root_i[R-2:0], ge};
            val_reg[k]  <= {val_i[IN_W-3:0], 2'b00};
            pay_reg[k]  <= pay_i;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[k] <= 1'b0;
            else
                v_reg[k] <= v_i;
        end
    end

    assign out_valid = v_reg[R-1];
    assign root      = root_reg[R-1];
    assign pay_out   = pay_reg[R-1];
endmodule
`default_nettype wire

>>> sv/lrpm_axis.sv
// Snell refraction of one axis: projected magnitude from axis offset and depth.
`default_nettype none
module lrpm_axis #(
    parameter int PAY_W = 1
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic [19:0]      a,
    input  logic [19:0]      nz,
    input  logic [15:0]      n,
    input  logic [PAY_W-1:0] pay_in,
    output logic             out_valid,
    output logic [19:0]      mag,
    output logic [PAY_W-1:0] pay_out
);
    import lrpm_pkg::*;

    localparam int SQ_PW  = 80 + PAY_W;
    localparam int DIV_PW = 40 + PAY_W;

    // stage 1: squares
    logic             v1_reg;
    logic [39:0]      aa1_reg, zz1_reg;
    logic [19:0]      a1_reg, nz1_reg;
    logic [PAY_W-1:0] p1_reg;
    // stage 2: P = a^2 + nz^2
    logic             v2_reg;
    logic [40:0]      pp2_reg;
    logic [39:0]      aa2_reg;
    logic [19:0]      a2_reg, nz2_reg;
    logic [PAY_W-1:0] p2_reg;
    // stage 3: n*P
    logic             v3_reg;
    logic [56:0]      np3_reg;
    logic [39:0]      aa3_reg;
    logic [19:0]      a3_reg, nz3_reg;
    logic [PAY_W-1:0] p3_reg;
    // stage 4: (n*P >> 13) * n
    logic             v4_reg;
    logic [59:0]      np4_reg;
    logic [39:0]      aa4_reg;
    logic [19:0]      a4_reg, nz4_reg;
    logic [PAY_W-1:0] p4_reg;
    // stage 5: radicand
    logic             v5_reg;
    logic [46:0]      r5_reg;
    logic [39:0]      aa5_reg;
    logic [19:0]      a5_reg, nz5_reg;
    logic [PAY_W-1:0] p5_reg;

    logic                   sq_v;
    logic [AX_SQRT_W/2-1:0] sq_q;
    logic [SQ_PW-1:0]       sq_pay;
    logic [19:0]            sq_a, sq_nz;
    logic [39:0]            sq_aa;
    logic [PAY_W-1:0]       sq_p;

    // stage 6: numerator and nz*q
    logic             v6_reg;
    logic [43:0]      num6_reg, nzq6_reg;
    logic [39:0]      aa6_reg;
    logic [19:0]      a6_reg, nz6_reg;
    logic [PAY_W-1:0] p6_reg;
    // stage 7: denominator
    logic             v7_reg;
    logic [43:0]      num7_reg;
    logic [44:0]      den7_reg;
    logic [19:0]      a7_reg, nz7_reg;
    logic [PAY_W-1:0] p7_reg;

    logic              dv_v;
    logic [AX_Q_W-1:0] dv_t;
    logic [DIV_PW-1:0] dv_pay;
    logic [19:0]       dv_a, dv_nz;
    logic [PAY_W-1:0]  dv_p;

    // stage 8: nz*t in two partial products
    logic             v8_reg;
    logic [42:0]      plo8_reg, phi8_reg;
    logic [19:0]      a8_reg;
    logic [PAY_W-1:0] p8_reg;
    // stage 9: clamp offset and move toward zero
    logic             v9_reg;
    logic [19:0]      mag9_reg;
    logic [PAY_W-1:0] p9_reg;

    logic [23:0] dq;
    logic [65:0] prod;
    logic [49:0] off;

    assign dq   = sq_q - {4'b0, sq_nz};
    assign prod = {phi8_reg, 23'b0} + {23'b0, plo8_reg};
    assign off  = prod[65:16];

    always_ff @(posedge clk)
    begin
        aa1_reg  <= a * a;
        zz1_reg  <= nz * nz;
        a1_reg   <= a;
        nz1_reg  <= nz;
        p1_reg   <= pay_in;

        pp2_reg  <= {1'b0, aa1_reg} + {1'b0, zz1_reg};
        aa2_reg  <= aa1_reg;
        a2_reg   <= a1_reg;
        nz2_reg  <= nz1_reg;
        p2_reg   <= p1_reg;

        np3_reg  <= pp2_reg * n;
        aa3_reg  <= aa2_reg;
        a3_reg   <= a2_reg;
        nz3_reg  <= nz2_reg;
        p3_reg   <= p2_reg;

        np4_reg  <= np3_reg[56:13] * n;
        aa4_reg  <= aa3_reg;
        a4_reg   <= a3_reg;
        nz4_reg  <= nz3_reg;
        p4_reg   <= p3_reg;

        // n >= 1.0 keeps this non-negative
        r5_reg   <= np4_reg[59:13] - {7'b0, aa4_reg};
        aa5_reg  <= aa4_reg;
        a5_reg   <= a4_reg;
        nz5_reg  <= nz4_reg;
        p5_reg   <= p4_reg;

        num6_reg <= sq_a * dq;
        nzq6_reg <= sq_nz * sq_q;
        aa6_reg  <= sq_aa;
        a6_reg   <= sq_a;
        nz6_reg  <= sq_nz;
        p6_reg   <= sq_p;

        num7_reg <= num6_reg;
        den7_reg <= {1'b0, nzq6_reg} + {5'b0, aa6_reg};
        a7_reg   <= a6_reg;
        nz7_reg  <= nz6_reg;
        p7_reg   <= p6_reg;

        plo8_reg <= dv_nz * dv_t[22:0];
        phi8_reg <= dv_nz * dv_t[45:23];
        a8_reg   <= dv_a;
        p8_reg   <= dv_p;

        mag9_reg <= (off > {30'b0, a8_reg}) ? 20'd0 : (a8_reg - off[19:0]);
        p9_reg   <= p8_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
            v8_reg <= 1'b0;
            v9_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            v6_reg <= sq_v;
            v7_reg <= v6_reg;
            v8_reg <= dv_v;
            v9_reg <= v8_reg;
        end
    end

    lrpm_isqrt #(
        .IN_W  (AX_SQRT_W),
        .PAY_W (SQ_PW)
    ) u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v5_reg),
        .val       ({1'b0, r5_reg}),
        .pay_in    ({a5_reg, nz5_reg, aa5_reg, p5_reg}),
        .out_valid (sq_v),
        .root      (sq_q),
        .pay_out   (sq_pay)
    );

    assign {sq_a, sq_nz, sq_aa, sq_p} = sq_pay;

    lrpm_div #(
        .NUM_W (60),
        .DEN_W (45),
        .Q_W   (AX_Q_W),
        .PAY_W (DIV_PW)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v7_reg),
        .num       ({num7_reg, 16'b0}),
        .den       (den7_reg),
        .pay_in    ({a7_reg, nz7_reg, p7_reg}),
        .out_valid (dv_v),
        .quo       (dv_t),
        .pay_out   (dv_pay)
    );

    assign {dv_a, dv_nz, dv_p} = dv_pay;

    assign out_valid = v9_reg;
    assign mag       = mag9_reg;
    assign pay_out   = p9_reg;
endmodule
`default_nettype wire

>>> sv/lens_refraction_pixel_map.sv
// Top level of the ellipsoid lens pixel mapper: config port, front and back ends.
`default_nettype none
`include "lens_refraction_pixel_map_defines.svh"
// One pixel coordinate is taken per clock (busy stays low) and its result leaves
// the fully pipelined arithmetic as a one-cycle done strobe with the result fields;
// the receiver cannot stall, so results must be taken as they appear. The pipeline
// holds 5 front stages (offsets, squares, ellipse test), a 40-stage depth divider,
// a 20-stage square root, 79 stages per refraction axis (two axes side by side,
// each with a 24-stage root and a 46-stage divider) and 2 output stages. Write
// configuration only while no pixel is in flight.
module lens_refraction_pixel_map #(
    parameter int MAX_DIM = 4096
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  lrpm_pkg::pixel_t    pixel,
    output logic                done,
    output lrpm_pkg::result_t   result,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [4:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);
    import lrpm_pkg::*;

    localparam logic [12:0] DIM_CAP = (MAX_DIM > 8191) ? 13'd8191 : 13'(MAX_DIM);
    localparam int FRONT_LAT = 5;
    localparam int DEPTH_Q_W = 40;
    localparam int DEPTH_R_W = 40;
    localparam int BACK_LAT  = 2;
    localparam int LATENCY   = FRONT_LAT + DEPTH_Q_W + DEPTH_R_W / 2 + AXIS_LAT + BACK_LAT;
    localparam int P0_W      = 29;

    // configuration
    logic [12:0] cfg_width_reg, cfg_height_reg;
    logic [15:0] cfg_index_reg;
    logic [1:0]  cfg_surr_reg;
    logic [2:0]  cfg_layout_reg;
    logic [23:0] cfg_bg_reg;
    logic        wr_en;
    logic [2:0]  reg_sel;

    logic [12:0] w_eff, h_eff;
    logic [15:0] n_eff;

    assign pready  = 1'b1;
    assign busy    = 1'b0;
    assign wr_en   = psel & penable & pwrite;
    assign reg_sel = paddr[4:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_width_reg  <= 13'd1;
            cfg_height_reg <= 13'd1;
            cfg_index_reg  <= INDEX_RESET;
            cfg_surr_reg   <= SUR_KEEP;
            cfg_layout_reg <= LAY_RGB;
            cfg_bg_reg     <= 24'd0;
        end
        else if (wr_en)
        begin
            unique case (reg_sel)
                REG_WIDTH:  cfg_width_reg  <= pwdata[12:0];
                REG_HEIGHT: cfg_height_reg <= pwdata[12:0];
                REG_INDEX:  cfg_index_reg  <= pwdata[15:0];
                REG_SURR:   cfg_surr_reg   <= pwdata[1:0];
                REG_LAYOUT: cfg_layout_reg <= pwdata[2:0];
                REG_BGCOL:  cfg_bg_reg     <= pwdata[23:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            REG_WIDTH:  prdata = {19'b0, cfg_width_reg};
            REG_HEIGHT: prdata = {19'b0, cfg_height_reg};
            REG_INDEX:  prdata = {16'b0, cfg_index_reg};
            REG_SURR:   prdata = {30'b0, cfg_surr_reg};
            REG_LAYOUT: prdata = {29'b0, cfg_layout_reg};
            REG_BGCOL:  prdata = {8'b0, cfg_bg_reg};
            default:    prdata = 32'd0;
        endcase
    end

    assign w_eff = (cfg_width_reg == 13'd0) ? 13'd1 :
                   (cfg_width_reg > DIM_CAP) ? DIM_CAP : cfg_width_reg;
    assign h_eff = (cfg_height_reg == 13'd0) ? 13'd1 :
                   (cfg_height_reg > DIM_CAP) ? DIM_CAP : cfg_height_reg;
    assign n_eff = (cfg_index_reg < INDEX_MIN) ? INDEX_MIN : cfg_index_reg;

    // front end
    logic               va_reg, vb_reg, vc_reg, vd_reg, ve_reg;
    logic [11:0]        col_reg, row_reg;
    logic signed [13:0] x_reg, y_reg;
    logic [12:0]        wb_reg, hb_reg, mb_reg;
    logic [14:0]        x15, y15;
    logic signed [27:0] xsq, ysq;
    logic [13:0]        xabs, yabs;
    logic [25:0]        xx_reg, yy_reg, w2_reg, h2_reg, m2c_reg, m2d_reg, m2e_reg;
    logic               xnc_reg, ync_reg, xnd_reg, ynd_reg, xne_reg, yne_reg;
    logic [12:0]        axc_reg, ayc_reg, axd_reg, ayd_reg, axe_reg, aye_reg;
    logic [51:0]        yw_reg, xh_reg, full_reg, d_reg;
    logic [52:0]        lhs;
    logic               in_lens;
    logic               in_e_reg;

    assign x15  = {2'b0, col_reg, 1'b0} - {2'b0, w_eff} + 15'd1;
    assign y15  = {2'b0, h_eff} - {2'b0, row_reg, 1'b0} - 15'd1;
    assign xsq  = x_reg * x_reg;
    assign ysq  = y_reg * y_reg;
    assign xabs = x_reg[13] ? (~x_reg + 14'd1) : x_reg;
    assign yabs = y_reg[13] ? (~y_reg + 14'd1) : y_reg;
    assign lhs  = {1'b0, yw_reg} + {1'b0, xh_reg};
    assign in_lens = lhs < {1'b0, full_reg};

    always_ff @(posedge clk)
    begin
        col_reg  <= pixel.pixel_col;
        row_reg  <= pixel.pixel_row;

        x_reg    <= x15[13:0];
        y_reg    <= y15[13:0];
        wb_reg   <= w_eff;
        hb_reg   <= h_eff;
        mb_reg   <= (w_eff > h_eff) ? w_eff : h_eff;

        xx_reg   <= xsq[25:0];
        yy_reg   <= ysq[25:0];
        w2_reg   <= wb_reg * wb_reg;
        h2_reg   <= hb_reg * hb_reg;
        m2c_reg  <= mb_reg * mb_reg;
        xnc_reg  <= x_reg[13];
        ync_reg  <= y_reg[13];
        axc_reg  <= xabs[12:0];
        ayc_reg  <= yabs[12:0];

        yw_reg   <= yy_reg * w2_reg;
        xh_reg   <= xx_reg * h2_reg;
        full_reg <= w2_reg * h2_reg;
        m2d_reg  <= m2c_reg;
        xnd_reg  <= xnc_reg;
        ynd_reg  <= ync_reg;
        axd_reg  <= axc_reg;
        ayd_reg  <= ayc_reg;

        in_e_reg <= in_lens;
        d_reg    <= in_lens ? (full_reg - lhs[51:0]) : 52'd0;
        m2e_reg  <= m2d_reg;
        xne_reg  <= xnd_reg;
        yne_reg  <= ynd_reg;
        axe_reg  <= axd_reg;
        aye_reg  <= ayd_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
            vd_reg <= 1'b0;
            ve_reg <= 1'b0;
        end
        else
        begin
            va_reg <= start & ~busy;
            vb_reg <= va_reg;
            vc_reg <= vb_reg;
            vd_reg <= vc_reg;
            ve_reg <= vd_reg;
        end
    end

    // depth: nz = isqrt(16384*D / M^2)
    logic                 dd_v, nz_v;
    logic [DEPTH_Q_W-1:0] dd_q;
    logic [P0_W-1:0]      dd_pay, nz_pay;
    logic [DEPTH_R_W/2-1:0] nz;
    logic                 nz_in, nz_xneg, nz_yneg;
    logic [12:0]          nz_ax, nz_ay;

    lrpm_div #(
        .NUM_W (66),
        .DEN_W (26),
        .Q_W   (DEPTH_Q_W),
        .PAY_W (P0_W)
    ) u_depth_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (ve_reg),
        .num       ({d_reg, 14'b0}),
        .den       (m2e_reg),
        .pay_in    ({in_e_reg, xne_reg, yne_reg, axe_reg, aye_reg}),
        .out_valid (dd_v),
        .quo       (dd_q),
        .pay_out   (dd_pay)
    );

    lrpm_isqrt #(
        .IN_W  (DEPTH_R_W),
        .PAY_W (P0_W)
    ) u_depth_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (dd_v),
        .val       (dd_q),
        .pay_in    (dd_pay),
        .out_valid (nz_v),
        .root      (nz),
        .pay_out   (nz_pay)
    );

    assign {nz_in, nz_xneg, nz_yneg, nz_ax, nz_ay} = nz_pay;

    // refraction per axis
    logic        ax_v, ay_v;
    logic [19:0] magx, magy;
    logic [1:0]  ax_pay;
    logic        ay_pay;

    lrpm_axis #(
        .PAY_W (2)
    ) u_axis_x (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (nz_v),
        .a         ({nz_ax, 7'b0}),
        .nz        (nz),
        .n         (n_eff),
        .pay_in    ({nz_in, nz_xneg}),
        .out_valid (ax_v),
        .mag       (magx),
        .pay_out   (ax_pay)
    );

    lrpm_axis #(
        .PAY_W (1)
    ) u_axis_y (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (nz_v),
        .a         ({nz_ay, 7'b0}),
        .nz        (nz),
        .n         (n_eff),
        .pay_in    (nz_yneg),
        .out_valid (ay_v),
        .mag       (magy),
        .pay_out   (ay_pay)
    );

    // back end
    logic        vf_reg, inf_reg;
    logic [22:0] px, py, sx, sy;
    logic [22:0] sx_reg, sy_reg;
    logic [13:0] sc, sr;
    logic [12:0] wm1, hm1;
    logic [11:0] cmax, rmax;
    logic [7:0]  alpha, red, green, blue;
    result_t     res_next, res_reg;
    logic        done_reg;

    assign px = ax_pay[0] ? (23'd0 - {3'b0, magx}) : {3'b0, magx};
    assign py = ay_pay ? (23'd0 - {3'b0, magy}) : {3'b0, magy};
    assign sx = px + {3'b0, w_eff, 7'b0};
    assign sy = {3'b0, h_eff, 7'b0} - py;

    always_ff @(posedge clk)
    begin
        sx_reg  <= sx;
        sy_reg  <= sy;
        inf_reg <= ax_pay[1];
    end

    assign sc   = sx_reg[22] ? 14'd0 : sx_reg[21:8];
    assign sr   = sy_reg[22] ? 14'd0 : sy_reg[21:8];
    assign wm1  = w_eff - 13'd1;
    assign hm1  = h_eff - 13'd1;
    assign cmax = wm1[12] ? 12'hFFF : wm1[11:0];
    assign rmax = hm1[12] ? 12'hFFF : hm1[11:0];

    assign alpha = (cfg_surr_reg == SUR_TRANS) ? 8'd0 : 8'd255;
    assign red   = cfg_bg_reg[23:16];
    assign green = cfg_bg_reg[15:8];
    assign blue  = cfg_bg_reg[7:0];

    always_comb
    begin
        res_next = '0;
        if (inf_reg)
        begin
            res_next.action     = ACT_COPY;
            res_next.source_col = (sc > {2'b0, cmax}) ? cmax : sc[11:0];
            res_next.source_row = (sr > {2'b0, rmax}) ? rmax : sr[11:0];
        end
        else if (cfg_surr_reg != SUR_BG && cfg_surr_reg != SUR_TRANS)
        begin
            res_next.action = ACT_KEEP;
        end
        else
        begin
            res_next.action = ACT_FILL;
            case (cfg_layout_reg)
                LAY_IDX:
                begin
                    res_next.fill_mask = 4'h1;
                end
                LAY_IDXA:
                begin
                    res_next.fill_chan1 = alpha;
                    res_next.fill_mask  = 4'h3;
                end
                LAY_RGB:
                begin
                    res_next.fill_chan0 = red;
                    res_next.fill_chan1 = green;
                    res_next.fill_chan2 = blue;
                    res_next.fill_mask  = 4'h7;
                end
                LAY_RGBA:
                begin
                    res_next.fill_chan0 = red;
                    res_next.fill_chan1 = green;
                    res_next.fill_chan2 = blue;
                    res_next.fill_chan3 = alpha;
                    res_next.fill_mask  = 4'hF;
                end
                LAY_GRAY:
                begin
                    res_next.fill_chan0 = red;
                    res_next.fill_mask  = 4'h1;
                end
                LAY_GRAYA:
                begin
                    res_next.fill_chan0 = red;
                    res_next.fill_chan1 = alpha;
                    res_next.fill_mask  = 4'h3;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vf_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            vf_reg   <= ax_v & ay_v;
            done_reg <= vf_reg;
        end
    end

    assign done   = done_reg;
    assign result = res_reg;

    `LRPM_ASSERT_IMP(a_latency, start && !busy, ##LATENCY done, "transaction result missing at fixed latency")
    `LRPM_ASSERT_IMP(a_axes_aligned, ax_v || ay_v, ax_v && ay_v, "axis pipelines out of step")
    `LRPM_ASSERT_IMP(a_noncopy_coords, done && result.action != ACT_COPY, result.source_col == 12'd0 && result.source_row == 12'd0, "source coordinate on non-copy result")
    `LRPM_ASSERT_NEVER(a_copy_no_fill, done && result.action == ACT_COPY && result.fill_mask != 4'd0, "fill mask on copy result")
endmodule
`default_nettype wire
